@@ hw/rtl/infrared_link_session_control_top_defines.svh @@
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef INFRARED_LINK_SESSION_CONTROL_TOP_DEFINES_SVH
`define INFRARED_LINK_SESSION_CONTROL_TOP_DEFINES_SVH

// same-cycle implication
`define ILSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ilsc assertion failed");

// next-cycle implication
`define ILSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ilsc assertion failed");

`endif

@@ hw/rtl/ilsc_pkg.sv @@
package ilsc_pkg;

  localparam int unsigned RetryLimitDefault = 5;
  localparam int unsigned RetryGapMsDefault = 50;

  localparam logic [7:0]  OwnUnitReset      = 8'hFF;
  localparam logic [31:0] TimeoutReset      = 32'd100;
  localparam logic [7:0]  PeerUnitReset     = 8'hFF;

  localparam logic [7:0] CmdConnect = 8'hFC;
  localparam logic [7:0] CmdReply   = 8'hFA;
  localparam logic [7:0] CmdAck     = 8'hF8;
  localparam logic [7:0] CmdRetry   = 8'hF6;
  localparam logic [7:0] CmdClose   = 8'hF4;
  localparam logic [7:0] CmdNoiseA  = 8'hFE;
  localparam logic [7:0] CmdNoiseB  = 8'hFF;

  typedef enum logic [0:0] {
    REG_OWN_UNIT = 1'b0,
    REG_TIMEOUT  = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_RECEIVE  = 2'd0,
    OP_CONNECT  = 2'd1,
    OP_SHUTDOWN = 2'd2,
    OP_SEND     = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_BARE    = 3'd1,
    ACT_LINK    = 3'd2,
    ACT_DATA    = 3'd3,
    ACT_RESEND  = 3'd4,
    ACT_DELIVER = 3'd5
  } action_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] now_ms;
    logic [7:0]  length;
    logic [7:0]  command;
    logic [7:0]  value;
    logic        checksum_ok;
  } item_t;

  typedef struct packed {
    logic [7:0]  own_unit;
    logic [31:0] disconnect_timeout;
  } cfg_t;

  typedef struct packed {
    action_e     action;
    logic [7:0]  action_command;
    logic [7:0]  action_value;
    logic [7:0]  action_length;
    logic        is_connected;
    logic        is_sender;
    logic        is_restoring;
    logic [7:0]  peer_unit_out;
    logic [31:0] retry_total;
  } result_t;

endpackage

@@ hw/rtl/ilsc_in_if.sv @@
interface ilsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] now_ms;
  logic [7:0]  length;
  logic [7:0]  command;
  logic [7:0]  value;
  logic        checksum_ok;

  modport source (
    output valid, opcode, now_ms, length, command, value, checksum_ok,
    input  ready
  );
  modport sink (
    input  valid, opcode, now_ms, length, command, value, checksum_ok,
    output ready
  );
endinterface

@@ hw/rtl/ilsc_out_if.sv @@
interface ilsc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  action_command;
  logic [7:0]  action_value;
  logic [7:0]  action_length;
  logic        is_connected;
  logic        is_sender;
  logic        is_restoring;
  logic [7:0]  peer_unit_out;
  logic [31:0] retry_total;

  modport source (
    output valid, action, action_command, action_value, action_length,
           is_connected, is_sender, is_restoring, peer_unit_out, retry_total,
    input  ready
  );
  modport sink (
    input  valid, action, action_command, action_value, action_length,
           is_connected, is_sender, is_restoring, peer_unit_out, retry_total,
    output ready
  );
endinterface

@@ hw/rtl/ilsc_session.sv @@
`include "infrared_link_session_control_top_defines.svh"

module ilsc_session #(
  parameter int unsigned RETRY_LIMIT  = ilsc_pkg::RetryLimitDefault,
  parameter int unsigned RETRY_GAP_MS = ilsc_pkg::RetryGapMsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  ilsc_pkg::item_t   item_i,
  input  ilsc_pkg::cfg_t    cfg_i,
  output ilsc_pkg::result_t res_o
);

  logic        connected_q, connected_d;
  logic        restoring_q, restoring_d;
  logic        trying_q, trying_d;
  logic        sender_q, sender_d;
  logic [2:0]  retry_count_q, retry_count_d;
  logic [31:0] retry_sum_q, retry_sum_d;
  logic [7:0]  peer_unit_q, peer_unit_d;
  logic [31:0] last_activity_q, last_activity_d;

  ilsc_pkg::action_e act;
  logic [7:0]  act_cmd, act_val, act_len;
  logic [31:0] gap;
  logic        got, do_poll, retry_fire, shut;

  always_comb begin
    connected_d     = connected_q;
    restoring_d     = restoring_q;
    trying_d        = trying_q;
    sender_d        = sender_q;
    retry_count_d   = retry_count_q;
    retry_sum_d     = retry_sum_q;
    peer_unit_d     = peer_unit_q;
    last_activity_d = last_activity_q;
    act             = ilsc_pkg::ACT_NONE;
    act_cmd         = 8'd0;
    act_val         = 8'd0;
    act_len         = 8'd0;
    gap             = item_i.now_ms - last_activity_q;
    got             = 1'b0;
    do_poll         = 1'b0;
    retry_fire      = 1'b0;
    shut            = 1'b0;

    case (item_i.opcode)
      ilsc_pkg::OP_RECEIVE: begin
        got = (item_i.length != 8'd0);
        if (item_i.length > 8'd1) begin
          if (!item_i.checksum_ok) begin
            if (connected_q) begin
              restoring_d = 1'b1;
              retry_sum_d = retry_sum_q + 32'd1;
            end
            got = 1'b0;
          end else begin
            retry_count_d = 3'd0;
          end
        end else if (item_i.command != ilsc_pkg::CmdConnect && connected_q) begin
          got = 1'b0;
        end

        if (!got) begin
          do_poll = 1'b1;
        end else begin
          last_activity_d = item_i.now_ms;
          case (item_i.command)
            ilsc_pkg::CmdConnect: begin
              if (!trying_q) begin
                trying_d = 1'b1;
                sender_d = 1'b0;
                if (!(item_i.length > 8'd1 && !connected_q)) begin
                  act     = ilsc_pkg::ACT_LINK;
                  act_cmd = ilsc_pkg::CmdReply;
                  act_val = cfg_i.own_unit;
                  if (connected_q) begin
                    restoring_d = 1'b1;
                    retry_sum_d = retry_sum_q + 32'd1;
                  end
                end
              end
            end
            ilsc_pkg::CmdReply: begin
              sender_d    = 1'b1;
              peer_unit_d = item_i.value;
              act         = ilsc_pkg::ACT_LINK;
              act_cmd     = ilsc_pkg::CmdAck;
              act_val     = cfg_i.own_unit;
              connected_d = 1'b1;
              restoring_d = 1'b0;
              trying_d    = 1'b0;
            end
            ilsc_pkg::CmdAck: begin
              peer_unit_d = item_i.value;
              if (restoring_q) begin
                act = ilsc_pkg::ACT_RESEND;
              end
              connected_d = 1'b1;
              restoring_d = 1'b0;
              trying_d    = 1'b0;
            end
            ilsc_pkg::CmdRetry: begin
              restoring_d = 1'b1;
            end
            ilsc_pkg::CmdNoiseA, ilsc_pkg::CmdNoiseB: begin
            end
            default: begin
              if (!restoring_q && connected_q) begin
                act     = ilsc_pkg::ACT_DELIVER;
                act_cmd = item_i.command;
                act_val = item_i.value;
                act_len = item_i.length;
              end
            end
          endcase
        end
      end
      ilsc_pkg::OP_CONNECT: begin
        if (!connected_q && !trying_q) begin
          trying_d        = 1'b1;
          act             = ilsc_pkg::ACT_BARE;
          act_cmd         = ilsc_pkg::CmdConnect;
          last_activity_d = item_i.now_ms;
        end
      end
      ilsc_pkg::OP_SHUTDOWN: begin
        shut = 1'b1;
      end
      default: begin
        if (connected_q) begin
          act     = ilsc_pkg::ACT_DATA;
          act_cmd = item_i.command;
          act_val = item_i.value;
          act_len = item_i.length;
        end
      end
    endcase

    // idle poll: paced retry, then silence timeout
    if (do_poll) begin
      retry_fire = restoring_d && (retry_count_d < 3'(RETRY_LIMIT)) && !trying_d
                   && (gap > 32'(RETRY_GAP_MS));
      if (retry_fire) begin
        if (sender_d) begin
          act     = ilsc_pkg::ACT_BARE;
          act_cmd = ilsc_pkg::CmdConnect;
        end else begin
          act     = ilsc_pkg::ACT_LINK;
          act_cmd = ilsc_pkg::CmdRetry;
          act_val = {5'd0, retry_count_d};
        end
        retry_count_d   = retry_count_d + 3'd1;
        last_activity_d = item_i.now_ms;
      end else if (cfg_i.disconnect_timeout != 32'd0 && gap > cfg_i.disconnect_timeout) begin
        if ((restoring_d && (retry_count_d < 3'(RETRY_LIMIT))) || connected_d) begin
          shut = 1'b1;
        end
        trying_d = 1'b0;
      end
    end

    if (shut) begin
      if (connected_d && !sender_d) begin
        act     = ilsc_pkg::ACT_LINK;
        act_cmd = ilsc_pkg::CmdClose;
        act_val = 8'd0;
        act_len = 8'd0;
      end
      retry_count_d = 3'd0;
      connected_d   = 1'b0;
      restoring_d   = 1'b0;
      trying_d      = 1'b0;
      sender_d      = 1'b0;
      retry_sum_d   = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connected_q     <= 1'b0;
      restoring_q     <= 1'b0;
      trying_q        <= 1'b0;
      sender_q        <= 1'b0;
      retry_count_q   <= 3'd0;
      retry_sum_q     <= 32'd0;
      peer_unit_q     <= ilsc_pkg::PeerUnitReset;
      last_activity_q <= 32'd0;
    end else if (fire_i) begin
      connected_q     <= connected_d;
      restoring_q     <= restoring_d;
      trying_q        <= trying_d;
      sender_q        <= sender_d;
      retry_count_q   <= retry_count_d;
      retry_sum_q     <= retry_sum_d;
      peer_unit_q     <= peer_unit_d;
      last_activity_q <= last_activity_d;
    end
  end

  always_comb begin
    res_o.action         = act;
    res_o.action_command = act_cmd;
    res_o.action_value   = act_val;
    res_o.action_length  = act_len;
    res_o.is_connected   = connected_d;
    res_o.is_sender      = sender_d;
    res_o.is_restoring   = restoring_d;
    res_o.peer_unit_out  = peer_unit_d;
    res_o.retry_total    = retry_sum_d;
  end

  `ILSC_ASSERT_NOW(a_retry_bounded, 1'b1, retry_count_q <= 3'(RETRY_LIMIT))
  `ILSC_ASSERT_NEXT(a_shutdown_clears,
                    fire_i && item_i.opcode == ilsc_pkg::OP_SHUTDOWN,
                    !connected_q && !restoring_q && retry_sum_q == 32'd0)
  `ILSC_ASSERT_NOW(a_deliver_connected, act == ilsc_pkg::ACT_DELIVER,
                   connected_q && !restoring_q)

endmodule

@@ hw/rtl/infrared_link_session_control_top.sv @@
// channel  dir  modport  payload
// in_i     in   sink     opcode, now_ms, length, command, value, checksum_ok
// out_o    out  source   action, action_*, is_*, peer_unit_out, retry_total
// cfg      in   plain    cfg_we_i, cfg_idx_i, cfg_data_i
//
// one word per cycle sustained while out_o.ready stays high
// the input register feeds the session logic, which loads the result register
// session state advances when a word moves from the input to the result register
// a stalled result holds; the input register still takes one word behind it
// asynchronous active-low reset clears flags, counters and valids

module infrared_link_session_control_top #(
  parameter int unsigned RETRY_LIMIT  = ilsc_pkg::RetryLimitDefault,
  parameter int unsigned RETRY_GAP_MS = ilsc_pkg::RetryGapMsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ilsc_in_if.sink     in_i,
  ilsc_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic              in_vld_q;
  ilsc_pkg::item_t   in_q;
  logic              out_vld_q;
  ilsc_pkg::result_t res_q;
  ilsc_pkg::result_t res_d;
  ilsc_pkg::cfg_t    cfg_q;
  logic              advance;

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cfg_q.own_unit           <= ilsc_pkg::OwnUnitReset;
      cfg_q.disconnect_timeout <= ilsc_pkg::TimeoutReset;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (ilsc_pkg::reg_idx_e'(cfg_idx_i))
          ilsc_pkg::REG_OWN_UNIT: cfg_q.own_unit           <= cfg_data_i[7:0];
          ilsc_pkg::REG_TIMEOUT:  cfg_q.disconnect_timeout <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.opcode      <= ilsc_pkg::opcode_e'(in_i.opcode);
      in_q.now_ms      <= in_i.now_ms;
      in_q.length      <= in_i.length;
      in_q.command     <= in_i.command;
      in_q.value       <= in_i.value;
      in_q.checksum_ok <= in_i.checksum_ok;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  ilsc_session #(
    .RETRY_LIMIT  (RETRY_LIMIT),
    .RETRY_GAP_MS (RETRY_GAP_MS)
  ) u_session (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  assign out_o.valid          = out_vld_q;
  assign out_o.action         = res_q.action;
  assign out_o.action_command = res_q.action_command;
  assign out_o.action_value   = res_q.action_value;
  assign out_o.action_length  = res_q.action_length;
  assign out_o.is_connected   = res_q.is_connected;
  assign out_o.is_sender      = res_q.is_sender;
  assign out_o.is_restoring   = res_q.is_restoring;
  assign out_o.peer_unit_out  = res_q.peer_unit_out;
  assign out_o.retry_total    = res_q.retry_total;

endmodule
